// ===== rtl/tcc_pkg.sv =====
// Shared types and constants of the terrain rule classifier.
// Depends on nothing; every other file of the block imports it.
package tcc_pkg;

  // Fixed field widths of the request and result items.
  localparam int OP_W        = 2;
  localparam int ENTRY_W     = 5;
  localparam int CLAUSE_W    = 2;
  localparam int MASK_W      = 64;
  localparam int COUNT_W     = 3;
  localparam int FIELD_SEL_W = 2;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 24;
  localparam int CODE_W      = 16;
  localparam int MODE_W      = 3;
  localparam int TYPE_IDX_W  = 5;
  localparam int TCOUNT_W    = 6;

  // Terrain code layout: four attribute fields of four bits, sixteen mask
  // slots per field.
  localparam int FIELD_COUNT = 4;
  localparam int ATTR_W      = 4;
  localparam int SLOTS       = 16;
  localparam int SLOT_IDX_W  = 6;

  // Attribute palettes: four fields of sixteen entries.
  localparam int PAL_DEPTH  = FIELD_COUNT * SLOTS;
  localparam int PAL_ADDR_W = 6;

  // Configuration port.
  localparam int            CFG_ADDR_W     = 3;
  localparam int            CFG_DATA_W     = 32;
  localparam logic [0:0]    REG_TYPE_COUNT = 1'b0;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_LOAD_MASK  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TYPE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_PAL   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY      = 2'd3;

  // Display modes.
  localparam logic [MODE_W-1:0] MODE_TYPE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ELEV = 3'd1;
  localparam logic [MODE_W-1:0] MODE_VEG  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SOIL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FEAT = 3'd4;

  // Attribute fields, also the palette selects.
  localparam logic [FIELD_SEL_W-1:0] FLD_ELEV = 2'd0;
  localparam logic [FIELD_SEL_W-1:0] FLD_VEG  = 2'd1;
  localparam logic [FIELD_SEL_W-1:0] FLD_SOIL = 2'd2;
  localparam logic [FIELD_SEL_W-1:0] FLD_FEAT = 2'd3;

  // Table write request, decoded once from an accepted load request.
  typedef struct packed {
    logic                   mask_we;
    logic                   type_we;
    logic                   pal_we;
    logic [ENTRY_W-1:0]     entry;
    logic [CLAUSE_W-1:0]    clause;
    logic [FIELD_SEL_W-1:0] field;
    logic [MASK_W-1:0]      mask;
    logic [COUNT_W-1:0]     count;
    logic [COLOR_W-1:0]     color;
  } tcc_load_t;

endpackage

// ===== rtl/tcc_match_unit.sv =====
// Shared match unit: tests one terrain type (all of its clauses) against a code.
// Depends on tcc_pkg.
module tcc_match_unit
  import tcc_pkg::*;
#(
  parameter int MAX_CLAUSES  = 4,
  parameter int FIELD_VALUES = 16
) (
  input  logic [MAX_CLAUSES-1:0][MASK_W-1:0] masks,
  input  logic [COUNT_W-1:0]                 count,
  input  logic [CODE_W-1:0]                  code,
  output logic                               match
);

  logic [MAX_CLAUSES-1:0] clause_hold;

  // A clause holds when any field's value has its slot set. Clauses past the
  // stored count are treated as holding, so a count above the clause limit
  // simply uses every clause.
  always_comb begin
    logic [ATTR_W-1:0]     attr;
    logic [SLOT_IDX_W-1:0] slot;
    for (int c = 0; c < MAX_CLAUSES; c++) begin
      clause_hold[c] = (c >= int'(count));
      for (int f = 0; f < FIELD_COUNT; f++) begin
        attr = code[f*ATTR_W +: ATTR_W];
        slot = {FIELD_SEL_W'(f), attr};
        if ((int'(attr) < FIELD_VALUES) && masks[c][slot]) begin
          clause_hold[c] = 1'b1;
        end
      end
    end
  end

  assign match = (count != '0) && (&clause_hold);

endmodule

// ===== rtl/tcc_rule_store.sv =====
// Rule tables: clause mask rows, clause counts and type colors, one row per type.
// Depends on tcc_pkg.
module tcc_rule_store
  import tcc_pkg::*;
#(
  parameter int MAX_TYPES   = 32,
  parameter int MAX_CLAUSES = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tcc_load_t                              load,
  input  logic                                   rd_en,
  input  logic [((MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1)-1:0] rd_row,
  output logic [MAX_CLAUSES-1:0][MASK_W-1:0]     rd_masks_r,
  output logic [COUNT_W-1:0]                     rd_count_r,
  input  logic                                   color_rd_en,
  input  logic [((MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1)-1:0] color_row,
  output logic [COLOR_W-1:0]                     color_r
);

  localparam int TIDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

  logic [MAX_CLAUSES-1:0][MASK_W-1:0] mask_mem [MAX_TYPES];
  logic [COLOR_W-1:0]                 color_mem [MAX_TYPES];
  logic [COUNT_W-1:0]                 count_r [MAX_TYPES];
  logic [TIDX_W-1:0]                  wr_row;

  assign wr_row = TIDX_W'(load.entry);

  // Mask memory: one row holds every clause of a type, written one clause lane
  // at a time and read as a whole row.
  always_ff @(posedge clk) begin
    if (load.mask_we) begin
      for (int c = 0; c < MAX_CLAUSES; c++) begin
        if (int'(load.clause) == c) begin
          mask_mem[wr_row][c] <= load.mask;
        end
      end
    end
    if (rd_en) begin
      rd_masks_r <= mask_mem[rd_row];
    end
  end

  // Clause counts reset to zero, so unloaded types never match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < MAX_TYPES; t++) begin
        count_r[t] <= '0;
      end
    end else if (load.type_we) begin
      count_r[wr_row] <= load.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_count_r <= count_r[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (load.type_we) begin
      color_mem[wr_row] <= load.color;
    end
    if (color_rd_en) begin
      color_r <= color_mem[color_row];
    end
  end

endmodule

// ===== rtl/tcc_palette.sv =====
// Attribute palettes: four fields of sixteen colors, with per-entry valid bits.
// Depends on tcc_pkg.
module tcc_palette
  import tcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcc_load_t             load,
  input  logic                  rd_en,
  input  logic [PAL_ADDR_W-1:0] rd_addr,
  output logic [COLOR_W-1:0]    color
);

  logic [COLOR_W-1:0]   pal_mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] valid_r;
  logic [COLOR_W-1:0]   rd_data_r;
  logic                 rd_valid_r;
  logic [PAL_ADDR_W-1:0] wr_addr;

  assign wr_addr = {load.field, load.entry[ATTR_W-1:0]};

  always_ff @(posedge clk) begin
    if (load.pal_we) begin
      pal_mem[wr_addr] <= load.color;
    end
    if (rd_en) begin
      rd_data_r <= pal_mem[rd_addr];
    end
  end

  // Entries read as black until they are first loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (load.pal_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign color = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== rtl/terrain_rule_classifier_color.sv =====
// Top level of the terrain rule classifier with display color.
// Depends on tcc_pkg, tcc_match_unit, tcc_rule_store and tcc_palette.
//
// Usage. Requests enter on the in_ channel (in_valid / in_stall) and are taken
// at a clock edge with in_valid high and in_stall low. Op 0, 1 and 2 requests
// load the clause masks, the type clause counts and colors, and the attribute
// palettes and give no result. An op 3 request is a query
// and gives exactly one result on the out_ channel (out_valid / out_stall).
// The type_count register sits at byte address 0 of the APB port; the user
// must write it only while the block is idle, as the block does not enforce it.
// Scanning. A query scans min(type_count, MAX_TYPES) types in index order
// through one shared match unit, one type per cycle, fed by the registered
// read port of the clause mask memory. The scan stops at the first matching
// type, or runs through all scanned types when none matches, and the
// result is then loaded into the output register from the final step.
// in_stall is high for the whole query, so the next request is taken only
// once the block has returned to idle after the result is loaded.
// The result register lets the block take load requests and a new query while
// the previous result waits; a finished query holds in its last step while
// out_stall keeps the output register full.
// Reset clears type_count, the clause counts and the palette valid bits. Mask
// and type color entries are undefined until loaded.
module terrain_rule_classifier_color
  import tcc_pkg::*;
#(
  parameter int MAX_TYPES    = 32,
  parameter int MAX_CLAUSES  = 4,
  parameter int FIELD_VALUES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Request channel.
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic [ENTRY_W-1:0]      in_entry_index,
  input  logic [CLAUSE_W-1:0]     in_clause_index,
  input  logic [MASK_W-1:0]       in_clause_mask,
  input  logic [COUNT_W-1:0]      in_clause_count,
  input  logic [FIELD_SEL_W-1:0]  in_palette_select,
  input  logic [CHAN_W-1:0]       in_red,
  input  logic [CHAN_W-1:0]       in_green,
  input  logic [CHAN_W-1:0]       in_blue,
  input  logic [CODE_W-1:0]       in_terrain_code,
  input  logic [MODE_W-1:0]       in_display_mode,
  // Result channel.
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_type_found,
  output logic [TYPE_IDX_W-1:0]   out_type_index,
  output logic [CHAN_W-1:0]       out_red,
  output logic [CHAN_W-1:0]       out_green,
  output logic [CHAN_W-1:0]       out_blue,
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int TIDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int CNT_W  = $clog2(MAX_TYPES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]    scan_n_r, scan_n_nxt;
  logic                ev_vld_r, ev_vld_nxt;
  logic [TIDX_W-1:0]   ev_idx_r, ev_idx_nxt;
  logic                found_r, found_nxt;
  logic [TIDX_W-1:0]   idx_r, idx_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic                sel_type_r, sel_type_nxt;
  logic                black_r, black_nxt;
  logic [TCOUNT_W-1:0] type_count_r;

  logic                out_valid_r;
  logic                out_found_r;
  logic [TYPE_IDX_W-1:0] out_tidx_r;
  logic [COLOR_W-1:0]  out_color_r;

  logic                accept;
  logic                query_acc;
  logic                cfg_we;
  logic                rd_en;
  logic                match;
  logic                hit;
  logic                scan_end;
  logic                out_free;
  logic                out_load;
  logic [COLOR_W-1:0]  type_color;
  logic [COLOR_W-1:0]  pal_color;
  logic [COLOR_W-1:0]  final_color;
  logic [MAX_CLAUSES-1:0][MASK_W-1:0] rd_masks;
  logic [COUNT_W-1:0]  rd_count;
  tcc_load_t           load;

  // Palette lookup chosen from the query request.
  logic [FIELD_SEL_W-1:0] pal_field;
  logic [ATTR_W-1:0]      pal_value;
  logic                   pal_black;
  logic [ATTR_W-1:0]      elev;

  // ---------------------------------------------------------------------------
  // Request handshake and load decode. Loads write the tables in the cycle they
  // are accepted; out-of-range loads are dropped here.
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign query_acc = accept && (in_op == OP_QUERY);

  always_comb begin
    load.mask_we = accept && (in_op == OP_LOAD_MASK) &&
                   (int'(in_entry_index) < MAX_TYPES) &&
                   (int'(in_clause_index) < MAX_CLAUSES);
    load.type_we = accept && (in_op == OP_LOAD_TYPE) &&
                   (int'(in_entry_index) < MAX_TYPES);
    load.pal_we  = accept && (in_op == OP_LOAD_PAL) &&
                   (int'(in_entry_index) < FIELD_VALUES) &&
                   (int'(in_entry_index) < SLOTS);
    load.entry   = in_entry_index;
    load.clause  = in_clause_index;
    load.field   = in_palette_select;
    load.mask    = in_clause_mask;
    load.count   = in_clause_count;
    load.color   = {in_red, in_green, in_blue};
  end

  // Modes 2 and 3 fall back to elevation entry 0 when the elevation is zero.
  assign elev = in_terrain_code[ATTR_W-1:0];

  always_comb begin
    pal_field = FLD_ELEV;
    pal_value = elev;
    pal_black = 1'b0;
    case (in_display_mode)
      MODE_TYPE: begin
        pal_black = 1'b1;
      end
      MODE_ELEV: begin
        pal_field = FLD_ELEV;
        pal_value = elev;
      end
      MODE_VEG: begin
        if (elev != '0) begin
          pal_field = FLD_VEG;
          pal_value = in_terrain_code[2*ATTR_W-1:ATTR_W];
        end
      end
      MODE_SOIL: begin
        if (elev != '0) begin
          pal_field = FLD_SOIL;
          pal_value = in_terrain_code[3*ATTR_W-1:2*ATTR_W];
        end
      end
      MODE_FEAT: begin
        pal_field = FLD_FEAT;
        pal_value = in_terrain_code[4*ATTR_W-1:3*ATTR_W];
      end
      default: begin
        pal_black = 1'b1;
      end
    endcase
    if (int'(pal_value) >= FIELD_VALUES) begin
      pal_black = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tables and the shared match unit.
  // ---------------------------------------------------------------------------
  tcc_rule_store #(
    .MAX_TYPES   (MAX_TYPES),
    .MAX_CLAUSES (MAX_CLAUSES)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .rd_en       (rd_en),
    .rd_row      (rd_cnt_r[TIDX_W-1:0]),
    .rd_masks_r  (rd_masks),
    .rd_count_r  (rd_count),
    .color_rd_en (hit),
    .color_row   (ev_idx_r),
    .color_r     (type_color)
  );

  tcc_palette u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .rd_en   (query_acc),
    .rd_addr ({pal_field, pal_value}),
    .color   (pal_color)
  );

  tcc_match_unit #(
    .MAX_CLAUSES  (MAX_CLAUSES),
    .FIELD_VALUES (FIELD_VALUES)
  ) u_match (
    .masks (rd_masks),
    .count (rd_count),
    .code  (code_r),
    .match (match)
  );

  // ---------------------------------------------------------------------------
  // Scan sequencer. The read counter issues one type row per cycle; the match
  // unit judges the row read in the previous cycle. The first hit stops the
  // scan and reads that type's color, so priority follows the index order.
  // ---------------------------------------------------------------------------
  assign rd_en    = (state_r == ST_SCAN) && (rd_cnt_r < scan_n_r);
  assign hit      = (state_r == ST_SCAN) && ev_vld_r && match;
  assign scan_end = hit || (!rd_en && !ev_vld_r);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_FIN) && out_free;

  always_comb begin
    state_nxt    = state_r;
    rd_cnt_nxt   = rd_cnt_r;
    scan_n_nxt   = scan_n_r;
    ev_vld_nxt   = ev_vld_r;
    ev_idx_nxt   = ev_idx_r;
    found_nxt    = found_r;
    idx_nxt      = idx_r;
    code_nxt     = code_r;
    sel_type_nxt = sel_type_r;
    black_nxt    = black_r;
    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt    = ST_SCAN;
          rd_cnt_nxt   = '0;
          // A type count above the table size scans the whole table.
          scan_n_nxt   = (int'(type_count_r) > MAX_TYPES) ? CNT_W'(MAX_TYPES)
                                                         : CNT_W'(type_count_r);
          ev_vld_nxt   = 1'b0;
          found_nxt    = 1'b0;
          idx_nxt      = '0;
          code_nxt     = in_terrain_code;
          sel_type_nxt = (in_display_mode == MODE_TYPE);
          black_nxt    = pal_black;
        end
      end
      ST_SCAN: begin
        ev_vld_nxt = rd_en && !scan_end;
        ev_idx_nxt = rd_cnt_r[TIDX_W-1:0];
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
        if (hit) begin
          found_nxt = 1'b1;
          idx_nxt   = ev_idx_r;
        end
        if (scan_end) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_cnt_r <= '0;
      scan_n_r <= '0;
      ev_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      scan_n_r <= scan_n_nxt;
      ev_vld_r <= ev_vld_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r   <= ev_idx_nxt;
    idx_r      <= idx_nxt;
    code_r     <= code_nxt;
    sel_type_r <= sel_type_nxt;
    black_r    <= black_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result register. Mode 0 shows the matched type's color, or black when no
  // type matched; the palette modes show the color read at acceptance, other modes black.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (sel_type_r) begin
      final_color = found_r ? type_color : '0;
    end else begin
      final_color = black_r ? '0 : pal_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= found_r;
      out_tidx_r  <= TYPE_IDX_W'(idx_r);
      out_color_r <= final_color;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_type_found = out_found_r;
  assign out_type_index = out_tidx_r;
  assign out_red        = out_color_r[3*CHAN_W-1:2*CHAN_W];
  assign out_green      = out_color_r[2*CHAN_W-1:CHAN_W];
  assign out_blue       = out_color_r[CHAN_W-1:0];

  // ---------------------------------------------------------------------------
  // Configuration port. Register index is the byte address divided by four;
  // writes to an address past the register list are dropped.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1:2] == REG_TYPE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_count_r <= '0;
    end else if (cfg_we) begin
      type_count_r <= pwdata[TCOUNT_W-1:0];
    end
  end

  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_TYPE_COUNT) ?
                  CFG_DATA_W'(type_count_r) : '0;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A result appears only when a finished query is handed to the output.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result raised outside the final step of a query");

  // The row under judgment is always the one just before the read counter.
  a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> ((CNT_W'(ev_idx_r) + CNT_W'(1)) == rd_cnt_r))
    else $error("match stage out of step with the read counter");

  // The read counter never runs past the scan length.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_cnt_r <= scan_n_r))
    else $error("read counter beyond scan length");

  // A reported match lies inside the scanned range.
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && found_r) |-> (CNT_W'(idx_r) < scan_n_r))
    else $error("matched type index outside the scanned types");

  // Once a query is taken the block refuses requests until it returns to idle.
  a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> in_stall)
    else $error("request channel open during a query");

endmodule
